/* rtl/core/sha1bh_pkg.sv */
// ----------------------------------------------------------------------------
// sha1bh_pkg
// Types and constants shared by the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1bh_pkg;

  localparam int unsigned NumChain  = 5;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 80;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hefcd_ab89;
  localparam logic [31:0] H2 = 32'h98ba_dcfe;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadByte  = 8'h80;
  // Highest pending byte count that still leaves room for the length words.
  localparam logic [5:0] PadLimit = 6'd55;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StAdd,
    StPad,
    StLen,
    StOut
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/sha1_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_req_i) takes one request
//   per message byte; byte_present marks a real byte and end_of_message closes
//   the message. The output channel (out_valid_o / out_ready_i / out_rsp_o)
//   returns the five digest words, word 0 first, last_word set on word 4.
//   A byte that does not fill the block is taken in the idle state. A byte that
//   fills the 64-byte block starts the 80 rounds of the single round unit,
//   then the chaining add. A closing request runs a pad step, a length step
//   and a compression (one more compression between pad and length if more
//   than 55 bytes are pending), then 5 output words at one per cycle when not
//   stalled.
//   in_ready_o is high only while idle. While the receiver stalls the current
//   digest word holds and nothing else advances.
//   Reset loads the SHA-1 initial chaining values, clears the block and the
//   byte counter; the same happens after the fifth digest word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hasher (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  sha1bh_pkg::in_req_t   in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output sha1bh_pkg::out_rsp_t  out_rsp_o
);

  sha1bh_pkg::state_e state_q, state_d;
  sha1bh_pkg::state_e ret_q, ret_d;

  logic [31:0] chain_q [sha1bh_pkg::NumChain];
  logic [31:0] chain_d [sha1bh_pkg::NumChain];
  logic [31:0] w_q [sha1bh_pkg::NumWords];
  logic [31:0] w_d [sha1bh_pkg::NumWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [63:0] cnt_q, cnt_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;

  logic [5:0]  pos;
  logic [5:0]  cnt_next_low;
  logic [4:0]  lane_sh;
  logic [31:0] wx, wt, f, k, tmp;
  logic [63:0] bits;

  assign pos     = cnt_q[5:0];
  assign lane_sh = {~pos[1:0], 3'b000};
  assign bits    = {cnt_q[60:0], 3'b000};
  assign cnt_next_low = pos + 6'd1;

  // Round unit: message schedule tap, round function, five-operand add.
  always_comb begin
    wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wt = (rnd_q < 7'd16) ? w_q[0] : {wx[30:0], wx[31]};
    if (rnd_q < 7'd20) begin
      f = d_q ^ (b_q & (c_q ^ d_q));
      k = sha1bh_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1bh_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (d_q & (b_q | c_q));
      k = sha1bh_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1bh_pkg::K3;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    chain_d = chain_q;
    w_d     = w_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      sha1bh_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i.byte_present) begin
            w_d[pos[5:2]][lane_sh +: 8] = in_req_i.data_byte;
            cnt_d = cnt_q + 64'd1;
          end
          if (in_req_i.byte_present && (cnt_next_low == 6'd0)) begin
            // block full: compress, then close or go back to idle
            state_d = sha1bh_pkg::StRound;
            ret_d   = in_req_i.end_of_message ? sha1bh_pkg::StPad : sha1bh_pkg::StIdle;
          end else if (in_req_i.end_of_message) begin
            state_d = sha1bh_pkg::StPad;
          end
          a_d   = chain_q[0];
          b_d   = chain_q[1];
          c_d   = chain_q[2];
          d_d   = chain_q[3];
          e_d   = chain_q[4];
          rnd_d = 7'd0;
        end
      end

      sha1bh_pkg::StPad: begin
        // later bytes are already zero since the block was cleared
        w_d[pos[5:2]][lane_sh +: 8] = sha1bh_pkg::PadByte;
        a_d   = chain_q[0];
        b_d   = chain_q[1];
        c_d   = chain_q[2];
        d_d   = chain_q[3];
        e_d   = chain_q[4];
        rnd_d = 7'd0;
        if (pos > sha1bh_pkg::PadLimit) begin
          state_d = sha1bh_pkg::StRound;
          ret_d   = sha1bh_pkg::StLen;
        end else begin
          state_d = sha1bh_pkg::StLen;
        end
      end

      sha1bh_pkg::StLen: begin
        w_d[14] = bits[63:32];
        w_d[15] = bits[31:0];
        a_d     = chain_q[0];
        b_d     = chain_q[1];
        c_d     = chain_q[2];
        d_d     = chain_q[3];
        e_d     = chain_q[4];
        rnd_d   = 7'd0;
        state_d = sha1bh_pkg::StRound;
        ret_d   = sha1bh_pkg::StOut;
      end

      sha1bh_pkg::StRound: begin
        for (int i = 0; i < sha1bh_pkg::NumWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[sha1bh_pkg::NumWords-1] = wt;
        e_d   = d_q;
        d_d   = c_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        b_d   = a_q;
        a_d   = tmp;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(sha1bh_pkg::NumRounds - 1)) begin
          state_d = sha1bh_pkg::StAdd;
        end
      end

      sha1bh_pkg::StAdd: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        for (int i = 0; i < sha1bh_pkg::NumWords; i++) begin
          w_d[i] = '0;
        end
        idx_d   = 3'd0;
        state_d = ret_q;
      end

      sha1bh_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(sha1bh_pkg::NumChain - 1)) begin
            // digest delivered: start the next message from scratch
            chain_d[0] = sha1bh_pkg::H0;
            chain_d[1] = sha1bh_pkg::H1;
            chain_d[2] = sha1bh_pkg::H2;
            chain_d[3] = sha1bh_pkg::H3;
            chain_d[4] = sha1bh_pkg::H4;
            cnt_d      = '0;
            idx_d      = 3'd0;
            state_d    = sha1bh_pkg::StIdle;
          end
        end
      end

      default: begin
        state_d = sha1bh_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_rsp_o.digest_word = chain_q[idx_q];
    out_rsp_o.word_index  = idx_q;
    out_rsp_o.last_word   = (idx_q == 3'(sha1bh_pkg::NumChain - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1bh_pkg::StIdle;
      ret_q      <= sha1bh_pkg::StIdle;
      chain_q[0] <= sha1bh_pkg::H0;
      chain_q[1] <= sha1bh_pkg::H1;
      chain_q[2] <= sha1bh_pkg::H2;
      chain_q[3] <= sha1bh_pkg::H3;
      chain_q[4] <= sha1bh_pkg::H4;
      for (int i = 0; i < sha1bh_pkg::NumWords; i++) begin
        w_q[i] <= '0;
      end
      cnt_q      <= '0;
      rnd_q      <= '0;
      idx_q      <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      chain_q <= chain_d;
      w_q     <= w_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  // Working variables carry no reset; they are loaded before each compression.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
  end

endmodule

`default_nettype wire
